[hw/rtl/sspr_pkg.sv]
// Shared types and constants for the servo status packet receiver.
// No dependencies; imported by the interface, controller, datapath and top.
package sspr_pkg;

  localparam int MAX_PARAMS = 32;
  localparam int PIDX_W     = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CNT_W      = 6;
  localparam int TICK_W     = 16;

  localparam logic [7:0]        HDR_BYTE      = 8'hFF;
  localparam logic [7:0]        ANY_ID        = 8'hFE;
  localparam logic [7:0]        LEN_OVERHEAD  = 8'd2;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd40;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    OC_OK       = 3'd0,
    OC_NORESP   = 3'd1,
    OC_BADCOUNT = 3'd2,
    OC_BADLEN   = 3'd3,
    OC_BADSUM   = 3'd4,
    OC_BADID    = 3'd5
  } outcome_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HUNT,
    ST_LEN,
    ST_ERR,
    ST_BODY,
    ST_CHK,
    ST_REPORT,
    ST_FETCH,
    ST_SEND
  } ctrl_state_t;

  typedef struct packed {
    logic     arm;
    logic     hc_inc;
    logic     hc_clr;
    logic     ld_id;
    logic     ld_len;
    logic     ld_err;
    logic     wr_param;
    logic     tick;
    logic     report;
    outcome_t outcome;
    logic     with_ids;
    logic     rep_last;
    logic     rd_step;
  } dp_cmd_t;

  typedef struct packed {
    logic count_bad;
    logic timeout_zero;
    logic deadline_end;
    logic is_ff;
    logic header_ok;
    logic len_ok;
    logic want_zero;
    logic body_done;
    logic sum_ok;
    logic id_ok;
    logic st_last;
    logic rd_last;
  } dp_stat_t;

endpackage

[hw/rtl/sspr_if.sv]
// Handshake channels of the servo status packet receiver: input items and results.
// Depends on sspr_pkg for the field widths.
interface sspr_item_if import sspr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [7:0]       byte_value;
  logic [CNT_W-1:0] expect_count;

  modport source (output valid, mode, byte_value, expect_count, input ready);
  modport sink   (input valid, mode, byte_value, expect_count, output ready);
endinterface

interface sspr_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] outcome;
  logic [7:0] servo_id;
  logic [7:0] fault_bits;
  logic [7:0] param_byte;
  logic       last;

  modport source (output valid, kind, outcome, servo_id, fault_bits, param_byte, last,
                  input ready);
  modport sink   (input valid, kind, outcome, servo_id, fault_bits, param_byte, last,
                  output ready);
endinterface

[hw/rtl/sspr_ctrl.sv]
// Controller: packet phase sequencing, handshakes and result ordering.
// Depends on sspr_pkg; drives datapath commands, reads datapath status.
module sspr_ctrl import sspr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic [1:0]  item_mode,
  output logic        item_ready,
  output logic        result_valid,
  input  logic        result_ready,
  input  dp_stat_t    stat,
  output dp_cmd_t     cmd
);

  ctrl_state_t state, state_next;
  logic        item_fire;
  logic        rx_state;

  always_comb begin
    case (state)
      ST_IDLE, ST_HUNT, ST_LEN, ST_ERR, ST_BODY, ST_CHK: rx_state = 1'b1;
      default: rx_state = 1'b0;
    endcase
  end

  assign item_ready   = rx_state;
  assign result_valid = (state == ST_REPORT) || (state == ST_SEND);
  assign item_fire    = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_HUNT, ST_LEN, ST_ERR, ST_BODY, ST_CHK: begin
        if (item_fire) begin
          if (item_mode == MODE_START) begin
            state_next = (stat.count_bad || stat.timeout_zero) ? ST_REPORT : ST_HUNT;
          end else if (item_mode == MODE_TICK) begin
            if (state != ST_IDLE && stat.deadline_end) state_next = ST_REPORT;
          end else if (item_mode == MODE_BYTE) begin
            case (state)
              ST_HUNT: begin
                if (!stat.is_ff && stat.header_ok) state_next = ST_LEN;
              end
              ST_LEN: state_next = ST_ERR;
              ST_ERR: begin
                if (!stat.len_ok) state_next = ST_REPORT;
                else state_next = stat.want_zero ? ST_CHK : ST_BODY;
              end
              ST_BODY: begin
                if (stat.body_done) state_next = ST_CHK;
              end
              ST_CHK: state_next = ST_REPORT;
              default: state_next = state;
            endcase
          end
        end
      end
      ST_REPORT: begin
        if (result_ready) state_next = stat.st_last ? ST_IDLE : ST_FETCH;
      end
      ST_FETCH: state_next = ST_SEND;
      ST_SEND: begin
        if (result_ready) state_next = stat.rd_last ? ST_IDLE : ST_FETCH;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.outcome = OC_OK;
    case (state)
      ST_IDLE, ST_HUNT, ST_LEN, ST_ERR, ST_BODY, ST_CHK: begin
        if (item_fire) begin
          if (item_mode == MODE_START) begin
            cmd.arm = 1'b1;
            if (stat.count_bad) begin
              cmd.report   = 1'b1;
              cmd.outcome  = OC_BADCOUNT;
              cmd.rep_last = 1'b1;
            end else if (stat.timeout_zero) begin
              cmd.report   = 1'b1;
              cmd.outcome  = OC_NORESP;
              cmd.rep_last = 1'b1;
            end
          end else if (item_mode == MODE_TICK) begin
            if (state != ST_IDLE) begin
              cmd.tick = 1'b1;
              if (stat.deadline_end) begin
                cmd.report   = 1'b1;
                cmd.outcome  = OC_NORESP;
                cmd.rep_last = 1'b1;
              end
            end
          end else if (item_mode == MODE_BYTE) begin
            case (state)
              ST_HUNT: begin
                if (stat.is_ff) cmd.hc_inc = 1'b1;
                else if (stat.header_ok) cmd.ld_id = 1'b1;
                else cmd.hc_clr = 1'b1;
              end
              ST_LEN: cmd.ld_len = 1'b1;
              ST_ERR: begin
                cmd.ld_err = 1'b1;
                if (!stat.len_ok) begin
                  cmd.report   = 1'b1;
                  cmd.outcome  = OC_BADLEN;
                  cmd.with_ids = 1'b1;
                  cmd.rep_last = 1'b1;
                end
              end
              ST_BODY: cmd.wr_param = 1'b1;
              ST_CHK: begin
                cmd.report   = 1'b1;
                cmd.with_ids = 1'b1;
                if (!stat.sum_ok) cmd.outcome = OC_BADSUM;
                else if (!stat.id_ok) cmd.outcome = OC_BADID;
                else cmd.outcome = OC_OK;
                cmd.rep_last = !(stat.sum_ok && stat.id_ok) || stat.want_zero;
              end
              default: cmd.report = 1'b0;
            endcase
          end
        end
      end
      ST_FETCH: cmd.rd_step = 1'b1;
      default: cmd.rd_step = 1'b0;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("input and result side open together");

  a_fetch_send: assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |=> state == ST_SEND)
    else $error("parameter fetch not followed by send");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND && result_ready && stat.rd_last) |=> state == ST_IDLE)
    else $error("last parameter beat did not end the receive");

  a_bad_count: assert property (@(posedge clk) disable iff (rst)
    (item_fire && item_mode == MODE_START && stat.count_bad) |=> state == ST_REPORT)
    else $error("oversized count not reported");

endmodule

[hw/rtl/sspr_dp.sv]
// Datapath: packet fields, checksum, deadline counter, parameter memory, result registers.
// Depends on sspr_pkg; steered by sspr_ctrl commands.
module sspr_dp import sspr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  input  logic [7:0]        byte_value,
  input  logic [CNT_W-1:0]  expect_count,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic              kind,
  output logic [2:0]        outcome,
  output logic [7:0]        servo_id,
  output logic [7:0]        fault_bits,
  output logic [7:0]        param_byte,
  output logic              last
);

  logic [TICK_W-1:0] timeout_ticks;
  logic [TICK_W-1:0] deadline_count;
  logic [1:0]        header_count;
  logic [7:0]        want_id;
  logic [CNT_W-1:0]  want_count;
  logic [7:0]        got_id;
  logic [7:0]        got_length;
  logic [7:0]        got_fault;
  logic [7:0]        running_sum;
  logic [CNT_W-1:0]  byte_index;
  logic [CNT_W-1:0]  rd_ptr;
  logic [7:0]        rd_data;
  logic              rd_last;
  logic              o_kind;
  outcome_t          st_outcome;
  logic [7:0]        st_id;
  logic [7:0]        st_fault;
  logic              st_last;
  logic [7:0]        mem [MAX_PARAMS];
  logic [CNT_W:0]    bi_inc;
  logic [CNT_W:0]    rd_inc;

  assign bi_inc = {1'b0, byte_index} + {{CNT_W{1'b0}}, 1'b1};
  assign rd_inc = {1'b0, rd_ptr} + {{CNT_W{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      byte_index   <= '0;
      rd_ptr       <= '0;
      o_kind       <= 1'b0;
    end else begin
      if (cmd.arm || cmd.hc_clr) header_count <= '0;
      else if (cmd.hc_inc && !header_count[1]) header_count <= header_count + 2'd1;
      if (cmd.arm) byte_index <= '0;
      else if (cmd.wr_param) byte_index <= bi_inc[CNT_W-1:0];
      if (cmd.report) begin
        rd_ptr <= '0;
        o_kind <= 1'b0;
      end else if (cmd.rd_step) begin
        rd_ptr <= rd_inc[CNT_W-1:0];
        o_kind <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arm) begin
      want_id        <= byte_value;
      want_count     <= expect_count;
      deadline_count <= timeout_ticks;
      got_id         <= '0;
      got_length     <= '0;
      got_fault      <= '0;
      running_sum    <= '0;
    end else begin
      if (cmd.tick && deadline_count != '0) deadline_count <= deadline_count - 1'b1;
      if (cmd.ld_id) begin
        got_id      <= byte_value;
        running_sum <= byte_value;
      end
      if (cmd.ld_len) got_length <= byte_value;
      if (cmd.ld_err) got_fault <= byte_value;
      if (cmd.ld_len || cmd.ld_err || cmd.wr_param) running_sum <= running_sum + byte_value;
    end
    if (cmd.report) begin
      st_outcome <= cmd.outcome;
      st_last    <= cmd.rep_last;
      st_id      <= cmd.with_ids ? got_id : 8'd0;
      st_fault   <= cmd.with_ids ? (cmd.ld_err ? byte_value : got_fault) : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_param) mem[byte_index[PIDX_W-1:0]] <= byte_value;
    if (cmd.rd_step) begin
      rd_data <= mem[rd_ptr[PIDX_W-1:0]];
      rd_last <= (rd_inc == {1'b0, want_count});
    end
  end

  always_comb begin
    stat.count_bad    = ({1'b0, expect_count} > (CNT_W+1)'(MAX_PARAMS));
    stat.timeout_zero = (timeout_ticks == '0);
    stat.deadline_end = (deadline_count <= {{(TICK_W-1){1'b0}}, 1'b1});
    stat.is_ff        = (byte_value == HDR_BYTE);
    stat.header_ok    = header_count[1];
    stat.len_ok       = (got_length == ({{(8-CNT_W){1'b0}}, want_count} + LEN_OVERHEAD));
    stat.want_zero    = (want_count == '0);
    stat.body_done    = (bi_inc >= {1'b0, want_count});
    stat.sum_ok       = (byte_value == ~running_sum);
    stat.id_ok        = (want_id == ANY_ID) || (got_id == want_id);
    stat.st_last      = st_last;
    stat.rd_last      = rd_last;
  end

  assign kind       = o_kind;
  assign outcome    = o_kind ? OC_OK : st_outcome;
  assign servo_id   = st_id;
  assign fault_bits = st_fault;
  assign param_byte = o_kind ? rd_data : 8'd0;
  assign last       = o_kind ? rd_last : st_last;

endmodule

[hw/rtl/servo_status_packet_receiver.sv]
// Top level of the servo status packet receiver: controller plus datapath.
// Depends on sspr_pkg, sspr_if, sspr_ctrl and sspr_dp.
//
// One input item is taken per cycle while a receive is being parsed: start, byte and
// tick items each finish in the cycle they are accepted. When a receive completes, the
// status beat is held in the output register and input stays closed until all results
// are taken; on success each parameter beat is then produced by a registered read of the
// parameter memory in the fetch state, then presented from that register in the send
// state. The parameter memory needs no clearing pass; only entries written in the
// current receive are read back.
module servo_status_packet_receiver import sspr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  sspr_item_if.sink         item,
  sspr_result_if.source     result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sspr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_mode    (item.mode),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  sspr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .byte_value   (item.byte_value),
    .expect_count (item.expect_count),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (result.kind),
    .outcome      (result.outcome),
    .servo_id     (result.servo_id),
    .fault_bits   (result.fault_bits),
    .param_byte   (result.param_byte),
    .last         (result.last)
  );

endmodule
